>>> hw/rtl/toy_risc_execute_with_cost_model_unit_macros.svh
// Assertion macros shared by the toy RISC execute unit.
// Every macro samples on clk_i and is switched off while rst_ni is low.
`ifndef TOY_RISC_EXECUTE_WITH_COST_MODEL_UNIT_MACROS_SVH
`define TOY_RISC_EXECUTE_WITH_COST_MODEL_UNIT_MACROS_SVH

// Plain property, checked at every rising clock edge out of reset.
`define TRCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next one.
`define TRCE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

>>> hw/rtl/trce_pkg.sv
// Shared types, constants and helpers of the toy RISC execute unit.
// Used by trce_front, trce_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package trce_pkg;

  localparam int unsigned MEM_WORDS_DEF = 256;
  localparam int unsigned NUM_REGS_DEF  = 6;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned REG_W    = 3;
  localparam int unsigned LABEL_W  = 16;
  localparam int unsigned COST_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Two-entry queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [COST_W-1:0] HIT_CYCLES_RST  = 8'd3;
  localparam logic [COST_W-1:0] MISS_CYCLES_RST = 8'd50;
  localparam logic [DATA_W-1:0] MARKER_RST      = 32'd128;
  localparam logic [COST_W-1:0] BASE_COST       = 8'd1;
  localparam logic [COST_W-1:0] CMP_COST        = 8'd2;

  typedef enum logic [2:0] {
    OP_MOV     = 3'd0,
    OP_ADD_REG = 3'd1,
    OP_ADD_IMM = 3'd2,
    OP_CMP     = 3'd3,
    OP_JMP     = 3'd4,
    OP_JE      = 3'd5,
    OP_LD      = 3'd6,
    OP_ST      = 3'd7
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIT_CYCLES   = 2'd0,
    CFG_MISS_CYCLES  = 2'd1,
    CFG_EMPTY_MARKER = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [COST_W-1:0] hit_cycles;
    logic [COST_W-1:0] miss_cycles;
    logic [DATA_W-1:0] empty_marker;
  } trce_cfg_t;

  // Decoded instruction as it waits in the queue.
  typedef struct packed {
    op_e                 op;
    logic [REG_W-1:0]    dest;
    logic [REG_W-1:0]    src;
    logic [DATA_W-1:0]   imm;
    logic [LABEL_W-1:0]  label;
    logic                wr_en;
    logic                is_ld;
    logic                is_st;
  } trce_item_t;

  typedef struct packed {
    logic                jump_taken;
    logic [LABEL_W-1:0]  jump_target;
    logic                addr_error;
    logic [DATA_W-1:0]   executed_total;
    logic [DATA_W-1:0]   cycle_total;
    logic [DATA_W-1:0]   hit_total;
    logic [DATA_W-1:0]   ldst_total;
  } trce_res_t;

  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? '1 : s[DATA_W-1:0];
  endfunction

endpackage

>>> hw/rtl/trce_front.sv
// Front end: decodes incoming instructions and holds them in a short queue.
// Depends on trce_pkg.
`timescale 1ns / 1ps

module trce_front #(
  parameter int unsigned NUM_REGS = trce_pkg::NUM_REGS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    kind_i,
  input  logic [trce_pkg::REG_W-1:0]    dest_reg_i,
  input  logic [trce_pkg::REG_W-1:0]    src_reg_i,
  input  logic [trce_pkg::DATA_W-1:0]   immediate_i,
  input  logic [trce_pkg::LABEL_W-1:0]  target_label_i,
  input  logic                          pop_i,
  output logic                          head_valid_o,
  output trce_pkg::trce_item_t          head_o
);
  import trce_pkg::*;

  trce_item_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]       cnt_q, cnt_d;
  trce_item_t              dec;
  logic                    push;
  logic                    dest_ok;

  always_comb begin
    dec       = '0;
    dec.op    = op_e'(kind_i);
    dec.dest  = dest_reg_i;
    dec.src   = src_reg_i;
    dec.imm   = immediate_i;
    dec.label = target_label_i;
    dest_ok   = 32'(dest_reg_i) < NUM_REGS;
    dec.wr_en = dest_ok && (dec.op inside {OP_MOV, OP_ADD_REG, OP_ADD_IMM, OP_LD});
    dec.is_ld = (dec.op == OP_LD);
    dec.is_st = (dec.op == OP_ST);
  end

  assign in_ready_o   = (cnt_q != QCNT_W'(QDEPTH));
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= dec;
    end
  end

endmodule

>>> hw/rtl/trce_back.sv
// Back end: register file, execute stage, data memory, commit stage with
// the cost counters, and the output register. Depends on trce_pkg and the
// assertion macros header.
`timescale 1ns / 1ps
`include "toy_risc_execute_with_cost_model_unit_macros.svh"

module trce_back #(
  parameter int unsigned MEM_WORDS = trce_pkg::MEM_WORDS_DEF,
  parameter int unsigned NUM_REGS  = trce_pkg::NUM_REGS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  trce_pkg::trce_cfg_t   cfg_i,
  input  logic                  head_valid_i,
  input  trce_pkg::trce_item_t  head_i,
  output logic                  pop_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output trce_pkg::trce_res_t   res_o
);
  import trce_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam logic [AW-1:0] LAST_IDX = AW'(MEM_WORDS - 1);

  // Register file and data memory.
  logic [DATA_W-1:0] rf_q  [NUM_REGS];
  logic [DATA_W-1:0] mem_q [MEM_WORDS];

  // Memory clearing pass after reset.
  logic              clearing_q;
  logic [AW-1:0]     clr_idx_q;

  // Execute stage.
  logic              a_valid_q;
  trce_item_t        a_item_q;
  logic [DATA_W-1:0] a_v1_q, a_v2_q;
  logic [DATA_W-1:0] rd1, rd2;
  logic [DATA_W-1:0] v1, v2, alu, addr;
  logic              taken, err, flag_d, flag_q;
  logic [AW-1:0]     a_idx;

  // Commit stage.
  logic              b_valid_q;
  logic              b_wr_en_q, b_is_ld_q, b_is_st_q, b_is_cmp_q;
  logic [REG_W-1:0]  b_widx_q;
  logic [DATA_W-1:0] b_alu_q, b_st_data_q;
  logic [AW-1:0]     b_idx_q;
  logic              b_taken_q, b_err_q;
  logic [LABEL_W-1:0] b_target_q;
  logic [DATA_W-1:0] rdata_q;
  logic              b_fwd_q;
  logic [DATA_W-1:0] b_fwd_data_q;
  logic [DATA_W-1:0] word, b_wdata;
  logic              b_we, b_fwd_ok, b_hit;
  logic [COST_W-1:0] cost;

  // Counters and output register.
  logic [DATA_W-1:0] exec_q, exec_d, cyc_q, cyc_d, hit_q, hit_d, ldst_q, ldst_d;
  logic              m_valid_q;
  trce_res_t         res_q;

  logic              pop, a_fire, b_fire;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  assign b_fire = b_valid_q && (!m_valid_q || res_ready_i);
  assign a_fire = a_valid_q && (!b_valid_q || b_fire);
  assign pop    = head_valid_i && !clearing_q && (!a_valid_q || a_fire);
  assign pop_o  = pop;

  // Commit-side write-back value; a load takes a just-older store's data.
  assign word     = b_fwd_q ? b_fwd_data_q : rdata_q;
  assign b_wdata  = b_is_ld_q ? word : b_alu_q;
  assign b_we     = b_fire && b_wr_en_q;
  assign b_fwd_ok = b_valid_q && b_wr_en_q;

  // Register read at dequeue, bypassing the write that lands at the same edge.
  always_comb begin
    rd1 = '0;
    rd2 = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      if (int'(head_i.dest) == i) rd1 = rf_q[i];
      if (int'(head_i.src)  == i) rd2 = rf_q[i];
    end
    if (b_we && (b_widx_q == head_i.dest)) rd1 = b_wdata;
    if (b_we && (b_widx_q == head_i.src))  rd2 = b_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      a_item_q <= head_i;
      a_v1_q   <= rd1;
      a_v2_q   <= rd2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) rf_q[i] <= '0;
    end else if (b_we) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (int'(b_widx_q) == i) rf_q[i] <= b_wdata;
      end
    end
  end

  // Execute: operands are forwarded from the instruction in the commit stage.
  always_comb begin
    v1     = (b_fwd_ok && (b_widx_q == a_item_q.dest)) ? b_wdata : a_v1_q;
    v2     = (b_fwd_ok && (b_widx_q == a_item_q.src))  ? b_wdata : a_v2_q;
    alu    = '0;
    addr   = '0;
    taken  = 1'b0;
    flag_d = flag_q;
    case (a_item_q.op)
      OP_MOV:     alu = a_item_q.imm;
      OP_ADD_REG: alu = v1 + v2;
      OP_ADD_IMM: alu = v1 + a_item_q.imm;
      OP_CMP:     flag_d = (v1 == v2);
      OP_JMP:     taken = 1'b1;
      OP_JE: begin
        taken  = flag_q;
        flag_d = 1'b0;
      end
      OP_LD:      addr = v2;
      OP_ST:      addr = v1;
      default:    alu = '0;
    endcase
    err = (a_item_q.is_ld || a_item_q.is_st) && (addr >= 32'(MEM_WORDS));
  end

  // Word index: a mask for a power-of-two size, otherwise a reciprocal
  // multiply whose quotient is at most one low, fixed by one subtract.
  if ((MEM_WORDS & (MEM_WORDS - 1)) == 0) begin : g_idx_mask
    assign a_idx = addr[AW-1:0];
  end else begin : g_idx_recip
    localparam logic [32:0] RECIP = 33'((65'd1 << (32 + AW)) / MEM_WORDS);
    logic [65:0]       prod;
    logic [DATA_W-1:0] q_est, rem;
    always_comb begin
      prod  = 66'(addr) * 66'(RECIP);
      q_est = DATA_W'(prod >> (32 + AW));
      rem   = addr - q_est * DATA_W'(MEM_WORDS);
      if (rem >= DATA_W'(MEM_WORDS)) rem = rem - DATA_W'(MEM_WORDS);
    end
    assign a_idx = rem[AW-1:0];
  end

  // Data memory: one write port (clear pass or store), one registered read.
  assign mem_we    = clearing_q || (b_fire && b_is_st_q);
  assign mem_waddr = clearing_q ? clr_idx_q : b_idx_q;
  assign mem_wdata = clearing_q ? MARKER_RST : b_st_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (a_fire) begin
      rdata_q <= mem_q[a_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_fwd_q      <= b_fire && b_is_st_q && (b_idx_q == a_idx);
      b_fwd_data_q <= b_st_data_q;
      b_wr_en_q    <= a_item_q.wr_en;
      b_is_ld_q    <= a_item_q.is_ld;
      b_is_st_q    <= a_item_q.is_st;
      b_is_cmp_q   <= (a_item_q.op == OP_CMP);
      b_widx_q     <= a_item_q.dest;
      b_alu_q      <= alu;
      b_st_data_q  <= v2;
      b_idx_q      <= a_idx;
      b_taken_q    <= taken;
      b_target_q   <= taken ? a_item_q.label : '0;
      b_err_q      <= err;
    end
  end

  // Commit: hit test against the current marker and the saturating counters.
  always_comb begin
    b_hit  = (b_is_ld_q || b_is_st_q) && (word != cfg_i.empty_marker);
    if (b_is_ld_q || b_is_st_q) begin
      cost = b_hit ? cfg_i.hit_cycles : cfg_i.miss_cycles;
    end else begin
      cost = b_is_cmp_q ? CMP_COST : BASE_COST;
    end
    exec_d = sat_add(exec_q, 32'd1);
    cyc_d  = sat_add(cyc_q, DATA_W'(cost));
    hit_d  = b_hit ? sat_add(hit_q, 32'd1) : hit_q;
    ldst_d = (b_is_ld_q || b_is_st_q) ? sat_add(ldst_q, 32'd1) : ldst_q;
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      res_q.jump_taken     <= b_taken_q;
      res_q.jump_target    <= b_target_q;
      res_q.addr_error     <= b_err_q;
      res_q.executed_total <= exec_d;
      res_q.cycle_total    <= cyc_d;
      res_q.hit_total      <= hit_d;
      res_q.ldst_total     <= ldst_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
      a_valid_q  <= 1'b0;
      b_valid_q  <= 1'b0;
      m_valid_q  <= 1'b0;
      flag_q     <= 1'b0;
      exec_q     <= '0;
      cyc_q      <= '0;
      hit_q      <= '0;
      ldst_q     <= '0;
    end else begin
      if (clearing_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == LAST_IDX) clearing_q <= 1'b0;
      end
      if (pop) begin
        a_valid_q <= 1'b1;
      end else if (a_fire) begin
        a_valid_q <= 1'b0;
      end
      if (a_fire) begin
        b_valid_q <= 1'b1;
        flag_q    <= flag_d;
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
      if (b_fire) begin
        m_valid_q <= 1'b1;
        exec_q    <= exec_d;
        cyc_q     <= cyc_d;
        hit_q     <= hit_d;
        ldst_q    <= ldst_d;
      end else if (res_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = m_valid_q;
  assign res_o       = res_q;

  `TRCE_ASSERT(a_no_pop_in_clear, clearing_q |-> !pop, "instruction taken during memory clear")
  `TRCE_ASSERT(a_pipe_empty_in_clear, clearing_q |-> (!a_valid_q && !b_valid_q),
               "pipeline busy during memory clear")
  `TRCE_ASSERT_NEXT(a_commit_reaches_out, b_fire, m_valid_q,
                    "committed instruction produced no result")
  `TRCE_ASSERT_NEXT(a_exec_count_step, b_fire && (exec_q != '1),
                    exec_q == $past(exec_q) + 32'd1, "instruction count did not advance by one")

endmodule

>>> hw/rtl/toy_risc_execute_with_cost_model_unit.sv
// Top level of the toy RISC execute unit with cycle cost model.
// Holds the configuration registers and joins trce_front and trce_back.
// Depends on trce_pkg, trce_front and trce_back.
//
//   Port group   Dir  Width  Contents
//   s_axis       in   56+3   decoded instruction, kind in tuser
//   m_axis       out  144+2  jump target and counters, flags in tuser
//   cfg          in   2+32   register index and write data
//
// One instruction per cycle sustained while m_axis is ready and the memory clear
// is over. After acceptance a result passes register read at dequeue, execute
// with memory read, then commit into the output register. A load feeds the next
// instruction through forwarding.
// After reset the data memory is cleared one word a cycle, through all MEM_WORDS words,
// while no instruction leaves the queue. A stalled m_axis side stops the back end;
// the two-entry queue keeps s_axis taking transfers meanwhile until it is full.
`timescale 1ns / 1ps

module toy_risc_execute_with_cost_model_unit #(
  parameter int unsigned MEM_WORDS = trce_pkg::MEM_WORDS_DEF,
  parameter int unsigned NUM_REGS  = trce_pkg::NUM_REGS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [2:0] dest_reg, [5:3] src_reg, [37:6] immediate, [53:38] target_label
  input  logic [55:0]                     s_axis_tdata,
  // [2:0] kind
  input  logic [2:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [15:0] jump_target, [47:16] executed_total, [79:48] cycle_total,
  // [111:80] hit_total, [143:112] ldst_total
  output logic [143:0]                    m_axis_tdata,
  // [0] jump_taken, [1] addr_error
  output logic [1:0]                      m_axis_tuser,
  input  logic                            cfg_we_i,
  input  logic [trce_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [trce_pkg::DATA_W-1:0]     cfg_data_i
);
  import trce_pkg::*;

  trce_cfg_t  cfg_q;
  trce_item_t head;
  trce_res_t  res;
  logic       head_valid, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hit_cycles   <= HIT_CYCLES_RST;
      cfg_q.miss_cycles  <= MISS_CYCLES_RST;
      cfg_q.empty_marker <= MARKER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HIT_CYCLES:   cfg_q.hit_cycles   <= cfg_data_i[COST_W-1:0];
        CFG_MISS_CYCLES:  cfg_q.miss_cycles  <= cfg_data_i[COST_W-1:0];
        CFG_EMPTY_MARKER: cfg_q.empty_marker <= cfg_data_i;
        default: ;
      endcase
    end
  end

  trce_front #(
    .NUM_REGS (NUM_REGS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .kind_i         (s_axis_tuser),
    .dest_reg_i     (s_axis_tdata[2:0]),
    .src_reg_i      (s_axis_tdata[5:3]),
    .immediate_i    (s_axis_tdata[37:6]),
    .target_label_i (s_axis_tdata[53:38]),
    .pop_i          (pop),
    .head_valid_o   (head_valid),
    .head_o         (head)
  );

  trce_back #(
    .MEM_WORDS (MEM_WORDS),
    .NUM_REGS  (NUM_REGS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {res.ldst_total, res.hit_total, res.cycle_total,
                         res.executed_total, res.jump_target};
  assign m_axis_tuser = {res.addr_error, res.jump_taken};

endmodule

>>> tb/toy_risc_execute_with_cost_model_unit_test.sv
// Self-checking testbench for toy_risc_execute_with_cost_model_unit.
// Needs only trce_pkg and the unit's RTL; holds its own execute and cost predictor.
// Directed corner cases first, then random instruction streams under several cost settings.
`timescale 1ns / 1ps

module toy_risc_execute_with_cost_model_unit_test;
  import trce_pkg::*;

  localparam int unsigned REGS  = NUM_REGS_DEF;
  localparam int unsigned WORDS = MEM_WORDS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned SEGMENTS = 6;
  localparam int unsigned BATCH    = 54;

  typedef struct packed {
    op_e                kind;
    logic [REG_W-1:0]   dest;
    logic [REG_W-1:0]   src;
    logic [DATA_W-1:0]  imm;
    logic [LABEL_W-1:0] label;
  } instr_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0]    cfg_data_i = '0;

  toy_risc_execute_with_cost_model_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Predicted machine state.
  logic [DATA_W-1:0] regs [REGS];
  logic [DATA_W-1:0] dmem [WORDS];
  logic              eq_flag;
  logic [DATA_W-1:0] exec_cnt, cyc_cnt, hit_cnt, ldst_cnt;
  logic [COST_W-1:0] hit_cost, miss_cost;
  logic [DATA_W-1:0] marker;

  instr_t    pending_instrs [$];
  trce_res_t expected_results [$];
  instr_t    in_flight;
  int unsigned send_idle_pct = 23;
  int unsigned recv_idle_pct = 72;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned jumps_seen = 0;
  int unsigned addr_errs_seen = 0;

  function automatic logic [DATA_W-1:0] add_sat(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    return (a > ~b) ? '1 : a + b;
  endfunction

  function automatic logic [DATA_W-1:0] read_reg(logic [REG_W-1:0] r);
    return (r < REGS) ? regs[r] : '0;
  endfunction

  function automatic void write_reg(logic [REG_W-1:0] r, logic [DATA_W-1:0] v);
    if (r < REGS) regs[r] = v;
  endfunction

  // A word that differs from the current marker counts as a hit.
  function automatic void charge_access(logic [DATA_W-1:0] word);
    if (word != marker) begin
      cyc_cnt = add_sat(cyc_cnt, DATA_W'(hit_cost));
      hit_cnt = add_sat(hit_cnt, 1);
    end else begin
      cyc_cnt = add_sat(cyc_cnt, DATA_W'(miss_cost));
    end
    ldst_cnt = add_sat(ldst_cnt, 1);
  endfunction

  function automatic trce_res_t execute_instr(instr_t in);
    trce_res_t r;
    logic [DATA_W-1:0] addr;
    r = '0;
    exec_cnt = add_sat(exec_cnt, 1);
    case (in.kind)
      OP_MOV: begin
        write_reg(in.dest, in.imm);
        cyc_cnt = add_sat(cyc_cnt, 1);
      end
      OP_ADD_REG: begin
        write_reg(in.dest, read_reg(in.dest) + read_reg(in.src));
        cyc_cnt = add_sat(cyc_cnt, 1);
      end
      OP_ADD_IMM: begin
        write_reg(in.dest, read_reg(in.dest) + in.imm);
        cyc_cnt = add_sat(cyc_cnt, 1);
      end
      OP_CMP: begin
        eq_flag = (read_reg(in.dest) == read_reg(in.src));
        cyc_cnt = add_sat(cyc_cnt, 2);
      end
      OP_JMP: begin
        r.jump_taken = 1'b1;
        cyc_cnt = add_sat(cyc_cnt, 1);
      end
      OP_JE: begin
        r.jump_taken = eq_flag;
        eq_flag = 1'b0;
        cyc_cnt = add_sat(cyc_cnt, 1);
      end
      OP_LD: begin
        addr = read_reg(in.src);
        r.addr_error = |addr[DATA_W-1:8];
        write_reg(in.dest, dmem[addr[7:0]]);
        charge_access(dmem[addr[7:0]]);
      end
      default: begin
        addr = read_reg(in.dest);
        r.addr_error = |addr[DATA_W-1:8];
        charge_access(dmem[addr[7:0]]);
        dmem[addr[7:0]] = read_reg(in.src);
      end
    endcase
    r.jump_target    = r.jump_taken ? in.label : '0;
    r.executed_total = exec_cnt;
    r.cycle_total    = cyc_cnt;
    r.hit_total      = hit_cnt;
    r.ldst_total     = ldst_cnt;
    return r;
  endfunction

  function automatic void check_field(int unsigned n, string name,
                                      logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0h, got %0h", n, name, want, got);
    end
  endfunction

  // Driver: one instruction per transfer, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(execute_instr(in_flight));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_instrs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_flight = pending_instrs.pop_front();
          s_axis_tdata  <= {2'b00, in_flight.label, in_flight.imm, in_flight.src, in_flight.dest};
          s_axis_tuser  <= in_flight.kind;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every result transfer with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    trce_res_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.jump_taken     = m_axis_tuser[0];
        got.addr_error     = m_axis_tuser[1];
        got.jump_target    = m_axis_tdata[15:0];
        got.executed_total = m_axis_tdata[47:16];
        got.cycle_total    = m_axis_tdata[79:48];
        got.hit_total      = m_axis_tdata[111:80];
        got.ldst_total     = m_axis_tdata[143:112];
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result %0d arrived with nothing predicted", results_seen);
        end else begin
          want = expected_results.pop_front();
          if (want.jump_taken) jumps_seen++;
          if (want.addr_error) addr_errs_seen++;
          check_field(results_seen, "jump_taken", DATA_W'(want.jump_taken),
                      DATA_W'(got.jump_taken));
          check_field(results_seen, "jump_target", DATA_W'(want.jump_target),
                      DATA_W'(got.jump_target));
          check_field(results_seen, "addr_error", DATA_W'(want.addr_error),
                      DATA_W'(got.addr_error));
          check_field(results_seen, "executed_total", want.executed_total, got.executed_total);
          check_field(results_seen, "cycle_total", want.cycle_total, got.cycle_total);
          check_field(results_seen, "hit_total", want.hit_total, got.hit_total);
          check_field(results_seen, "ldst_total", want.ldst_total, got.ldst_total);
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic instr_t make_instr(op_e kind, logic [REG_W-1:0] d, logic [REG_W-1:0] s,
                                        logic [DATA_W-1:0] imm, logic [LABEL_W-1:0] lbl);
    instr_t i;
    i.kind  = kind;
    i.dest  = d;
    i.src   = s;
    i.imm   = imm;
    i.label = lbl;
    return i;
  endfunction

  // Mostly valid register numbers, now and then one of the two missing ones.
  function automatic logic [REG_W-1:0] pick_reg();
    if ($urandom_range(0, 9) == 0) return REG_W'($urandom_range(6, 7));
    return REG_W'($urandom_range(0, 5));
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return marker;
      3, 4, 5: return $urandom;
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  // Address that usually lands inside memory, on a few words so that hits happen.
  function automatic logic [DATA_W-1:0] pick_addr();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1, 2:    return $urandom_range(0, 255);
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  task automatic push_random(int unsigned n);
    int unsigned made;
    logic [REG_W-1:0] a, b;
    made = 0;
    while (made < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          a = REG_W'($urandom_range(0, 5));
          pending_instrs.push_back(make_instr(OP_MOV, a, pick_reg(), pick_addr(),
                                              LABEL_W'($urandom)));
          if ($urandom_range(0, 1) != 0)
            pending_instrs.push_back(make_instr(OP_LD, pick_reg(), a, $urandom,
                                                LABEL_W'($urandom)));
          else
            pending_instrs.push_back(make_instr(OP_ST, a, pick_reg(), $urandom,
                                                LABEL_W'($urandom)));
          made += 2;
        end
        4: begin
          a = pick_reg();
          b = ($urandom_range(0, 2) == 0) ? a : pick_reg();
          pending_instrs.push_back(make_instr(OP_CMP, a, b, $urandom, LABEL_W'($urandom)));
          pending_instrs.push_back(make_instr(OP_JE, pick_reg(), pick_reg(), $urandom,
                                              LABEL_W'($urandom)));
          made += 2;
        end
        default: begin
          pending_instrs.push_back(make_instr(op_e'($urandom_range(0, 7)), pick_reg(), pick_reg(),
                                              pick_value(), LABEL_W'($urandom)));
          made++;
        end
      endcase
    end
  endtask

  task automatic write_cost_cfg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_HIT_CYCLES:   hit_cost  = value[COST_W-1:0];
      CFG_MISS_CYCLES:  miss_cost = value[COST_W-1:0];
      CFG_EMPTY_MARKER: marker    = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every queued instruction has gone and every result has come back.
  // The check runs at the falling edge, once the driver and monitor have settled.
  task automatic drain();
    while (pending_instrs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    foreach (regs[i]) regs[i] = '0;
    foreach (dmem[i]) dmem[i] = MARKER_RST;
    eq_flag   = 1'b0;
    exec_cnt  = '0;
    cyc_cnt   = '0;
    hit_cnt   = '0;
    ldst_cnt  = '0;
    hit_cost  = HIT_CYCLES_RST;
    miss_cost = MISS_CYCLES_RST;
    marker    = MARKER_RST;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners: wrap-around, flag handling, hits and misses, bad addresses
    // and the two register numbers that do not exist.
    pending_instrs.push_back(make_instr(OP_MOV, 0, 0, 32'h7FFF_FFFF, 0));
    pending_instrs.push_back(make_instr(OP_MOV, 1, 0, 32'h8000_0000, 0));
    pending_instrs.push_back(make_instr(OP_ADD_REG, 0, 1, 0, 0));
    pending_instrs.push_back(make_instr(OP_ADD_IMM, 0, 0, 32'd1, 0));
    pending_instrs.push_back(make_instr(OP_ADD_IMM, 2, 0, 32'hFFFF_FFFF, 0));
    pending_instrs.push_back(make_instr(OP_CMP, 0, 2, 0, 0));
    pending_instrs.push_back(make_instr(OP_JE, 0, 0, 0, 16'hFFFF));
    pending_instrs.push_back(make_instr(OP_CMP, 0, 3, 0, 0));
    pending_instrs.push_back(make_instr(OP_JE, 0, 0, 0, 16'hFFFF));
    pending_instrs.push_back(make_instr(OP_JE, 0, 0, 0, 16'h5A5A));
    pending_instrs.push_back(make_instr(OP_JMP, 0, 0, 0, 16'h0000));
    pending_instrs.push_back(make_instr(OP_JMP, 7, 7, 32'hFFFF_FFFF, 16'hFFFF));
    pending_instrs.push_back(make_instr(OP_ST, 0, 1, 0, 0));
    pending_instrs.push_back(make_instr(OP_ST, 0, 2, 0, 0));
    pending_instrs.push_back(make_instr(OP_LD, 3, 0, 0, 0));
    pending_instrs.push_back(make_instr(OP_MOV, 4, 0, 32'd300, 0));
    pending_instrs.push_back(make_instr(OP_LD, 5, 4, 0, 0));
    pending_instrs.push_back(make_instr(OP_ST, 2, 5, 0, 0));
    pending_instrs.push_back(make_instr(OP_LD, 5, 2, 0, 0));
    pending_instrs.push_back(make_instr(OP_MOV, 6, 0, 32'd5, 0));
    pending_instrs.push_back(make_instr(OP_CMP, 6, 7, 0, 0));
    pending_instrs.push_back(make_instr(OP_ADD_REG, 0, 7, 0, 0));
    pending_instrs.push_back(make_instr(OP_LD, 7, 0, 0, 0));
    pending_instrs.push_back(make_instr(OP_ST, 7, 3, 0, 0));
    // The memory clear after reset must finish before any register write.
    drain();
    repeat (WORDS + 16) @(posedge clk_i);

    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin send_idle_pct = 23; recv_idle_pct = 72; end
        1: begin send_idle_pct = 72; recv_idle_pct = 23; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (seg)
        1: begin
          write_cost_cfg(CFG_HIT_CYCLES, 32'd0);
          write_cost_cfg(CFG_MISS_CYCLES, 32'd255);
          write_cost_cfg(CFG_EMPTY_MARKER, 32'h8000_0000);
        end
        2: begin
          write_cost_cfg(CFG_HIT_CYCLES, 32'd255);
          write_cost_cfg(CFG_MISS_CYCLES, 32'd0);
          write_cost_cfg(CFG_EMPTY_MARKER, 32'h7FFF_FFFF);
          write_cost_cfg(CFG_UNUSED, $urandom);
        end
        3: begin
          write_cost_cfg(CFG_HIT_CYCLES, 32'd7);
          write_cost_cfg(CFG_MISS_CYCLES, 32'd1);
          write_cost_cfg(CFG_EMPTY_MARKER, 32'd0);
        end
        4: begin
          write_cost_cfg(CFG_HIT_CYCLES, $urandom);
          write_cost_cfg(CFG_MISS_CYCLES, $urandom);
          write_cost_cfg(CFG_EMPTY_MARKER, $urandom);
        end
        5: begin
          write_cost_cfg(CFG_HIT_CYCLES, DATA_W'(HIT_CYCLES_RST));
          write_cost_cfg(CFG_MISS_CYCLES, DATA_W'(MISS_CYCLES_RST));
          write_cost_cfg(CFG_EMPTY_MARKER, MARKER_RST);
        end
        default: ;
      endcase
      // Two batches per setting; the sender waits for a full drain in between.
      push_random(BATCH);
      drain();
      push_random(BATCH);
      drain();
    end

    repeat (16) @(posedge clk_i);
    if (expected_results.size() != 0) mismatches++;
    $display("Checked %0d results across six cost settings and three idle patterns.",
             results_seen);
    $display("Saw %0d loads/stores with %0d hits, %0d jumps taken, %0d bad addresses.",
             ldst_cnt, hit_cnt, jumps_seen, addr_errs_seen);
    if (mismatches == 0) begin
      $display("toy_risc_execute_with_cost_model_unit_test: done, clean");
    end else begin
      $display("toy_risc_execute_with_cost_model_unit_test: done, errors");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("Run timed out with %0d results outstanding.", expected_results.size());
    $display("toy_risc_execute_with_cost_model_unit_test: done, errors");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/trce_pkg.sv
hw/rtl/trce_front.sv
hw/rtl/trce_back.sv
hw/rtl/toy_risc_execute_with_cost_model_unit.sv
tb/toy_risc_execute_with_cost_model_unit_test.sv
